[rtl/tcbk_pkg.sv]
// Shared codes, queue entry type and defaults for the TCB key tangent block.
`default_nettype none

package tcbk_pkg;

  // Mode codes on the func input
  localparam logic [2:0] FUNC_INTERIOR   = 3'd0;
  localparam logic [2:0] FUNC_FIRST_OPEN = 3'd1;
  localparam logic [2:0] FUNC_LAST_OPEN  = 3'd2;
  localparam logic [2:0] FUNC_FIRST_LOOP = 3'd3;
  localparam logic [2:0] FUNC_LAST_LOOP  = 3'd4;
  localparam logic [2:0] FUNC_TWO_KEY    = 3'd5;

  // Request class after decode
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_TCB        = 3'd1;
  localparam logic [2:0] KIND_OPEN_FIRST = 3'd2;
  localparam logic [2:0] KIND_OPEN_LAST  = 3'd3;
  localparam logic [2:0] KIND_TWO_KEY    = 3'd4;

  localparam int QUEUE_DEPTH = 4;

  // One classified request, as it sits in the queue
  typedef struct packed {
    logic [2:0]         kind;
    logic               span_zero;
    logic               neg_p;
    logic               neg_n;
    logic [16:0]        dfp_mag;
    logic [16:0]        dfn_mag;
    logic [16:0]        span_mag;
    logic signed [32:0] dm;
    logic signed [32:0] dp;
    logic signed [15:0] tension;
    logic signed [15:0] continuity;
    logic signed [15:0] bias;
    logic signed [15:0] next_tension;
    logic signed [31:0] nb;
  } entry_t;

endpackage

`default_nettype wire

[rtl/tcbk_front.sv]
// Front end: loop length register, mode decode and frame/value differences.
`default_nettype none

module tcbk_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [2:0]         func,
  input  wire logic [15:0]        prev_frame,
  input  wire logic [15:0]        cur_frame,
  input  wire logic [15:0]        next_frame,
  input  wire logic signed [31:0] prev_value,
  input  wire logic signed [31:0] cur_value,
  input  wire logic signed [31:0] next_value,
  input  wire logic signed [15:0] tension,
  input  wire logic signed [15:0] continuity,
  input  wire logic signed [15:0] bias,
  input  wire logic signed [31:0] neighbor_tangent,
  input  wire logic signed [15:0] next_tension,
  output tcbk_pkg::entry_t        entry
);

  logic [15:0] loop_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= '0;
    end else if (cfg_write) begin
      loop_length <= cfg_data;
    end
  end

  logic signed [17:0] pf, cf, nf, ll, span, dfp, dfn, ap, an, as;
  logic [2:0]         kind;

  always_comb begin
    unique case (func) inside
      tcbk_pkg::FUNC_INTERIOR, tcbk_pkg::FUNC_FIRST_LOOP, tcbk_pkg::FUNC_LAST_LOOP: begin
        kind = tcbk_pkg::KIND_TCB;
      end
      tcbk_pkg::FUNC_FIRST_OPEN: begin
        kind = tcbk_pkg::KIND_OPEN_FIRST;
      end
      tcbk_pkg::FUNC_LAST_OPEN: begin
        kind = tcbk_pkg::KIND_OPEN_LAST;
      end
      tcbk_pkg::FUNC_TWO_KEY: begin
        kind = tcbk_pkg::KIND_TWO_KEY;
      end
      default: begin
        kind = tcbk_pkg::KIND_NONE;
      end
    endcase
  end

  always_comb begin
    pf = $signed({2'b00, prev_frame});
    cf = $signed({2'b00, cur_frame});
    nf = $signed({2'b00, next_frame});
    ll = $signed({2'b00, loop_length});
    // loop modes widen the gap that crosses the wrap, and the span with it
    span = nf - pf + ((func == tcbk_pkg::FUNC_FIRST_LOOP || func == tcbk_pkg::FUNC_LAST_LOOP)
                      ? ll : 18'sd0);
    dfp  = cf - pf + ((func == tcbk_pkg::FUNC_FIRST_LOOP) ? ll : 18'sd0);
    dfn  = nf - cf + ((func == tcbk_pkg::FUNC_LAST_LOOP) ? ll : 18'sd0);
    ap   = dfp[17]  ? -dfp  : dfp;
    an   = dfn[17]  ? -dfn  : dfn;
    as   = span[17] ? -span : span;

    entry.kind         = kind;
    entry.span_zero    = (span == 18'sd0);
    entry.neg_p        = dfp[17] ^ span[17];
    entry.neg_n        = dfn[17] ^ span[17];
    entry.dfp_mag      = ap[16:0];
    entry.dfn_mag      = an[16:0];
    entry.span_mag     = as[16:0];
    entry.dm           = $signed({cur_value[31], cur_value}) -
                         $signed({prev_value[31], prev_value});
    entry.dp           = $signed({next_value[31], next_value}) -
                         $signed({cur_value[31], cur_value});
    entry.tension      = tension;
    entry.continuity   = continuity;
    entry.bias         = bias;
    entry.next_tension = next_tension;
    entry.nb           = neighbor_tangent;
  end

endmodule

`default_nettype wire

[rtl/tcbk_fifo.sv]
// Short request queue between the front end and the arithmetic pipeline.
`default_nettype none

module tcbk_fifo #(
  parameter int DEPTH = tcbk_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  tcbk_pkg::entry_t      push_data,
  output logic                  full,
  input  wire logic             pop,
  output tcbk_pkg::entry_t      head,
  output logic                  not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tcbk_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[rtl/tcbk_back.sv]
// Arithmetic pipeline: frame ratio divider, TCB weights, tangent sums, output stage.
`default_nettype none

module tcbk_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  tcbk_pkg::entry_t        head,
  input  wire logic               head_valid,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      in_tangent,
  output logic signed [31:0]      out_tangent,
  output logic signed [31:0]      next_in_tangent
);

  localparam int NS       = 18;  // pipeline stages
  localparam int DIV_LAST = 9;   // last stage with divider steps

  localparam logic signed [16:0] ONE17 = 17'sd16384;

  typedef struct packed {
    logic [18:0] rem;
    logic [17:0] nlo;
    logic [17:0] q;
  } dv_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               span_zero;
    logic               neg_p;
    logic               neg_n;
    logic               ovf_p;
    logic               ovf_n;
    logic [17:0]        dd;
    dv_t                dv_p;
    dv_t                dv_n;
    logic signed [32:0] dm;
    logic signed [32:0] dp;
    logic signed [16:0] tm2;
    logic signed [16:0] cm;
    logic signed [16:0] cp;
    logic signed [16:0] bm;
    logic signed [16:0] bp;
    logic signed [16:0] ntm;
    logic [16:0]        fc;
    logic signed [17:0] g;
    logic signed [35:0] e;
    logic signed [18:0] tmcm;
    logic signed [18:0] tmcp;
    logic signed [52:0] eprod;
    logic signed [49:0] nprod;
    logic signed [31:0] oval;
    logic signed [31:0] nval;
    logic signed [35:0] pb_sm;
    logic signed [35:0] pb_sp;
    logic signed [35:0] pb_dm;
    logic signed [35:0] pb_dp;
    logic signed [17:0] fr_p;
    logic signed [17:0] fr_n;
    logic signed [36:0] ad_p;
    logic signed [36:0] ad_n;
    logic signed [17:0] fp;
    logic signed [17:0] fn;
    logic signed [53:0] kr_sm;
    logic signed [53:0] kr_sp;
    logic signed [53:0] kr_dm;
    logic signed [53:0] kr_dp;
    logic signed [25:0] ks_sm;
    logic signed [25:0] ks_sp;
    logic signed [25:0] ks_dm;
    logic signed [25:0] ks_dp;
    logic signed [58:0] m_sm;
    logic signed [58:0] m_sp;
    logic signed [58:0] m_dm;
    logic signed [58:0] m_dp;
    logic signed [59:0] sum_s;
    logic signed [59:0] sum_d;
    logic signed [31:0] in_t;
    logic signed [31:0] out_t;
    logic signed [31:0] next_t;
  } bk_t;

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int n);
    logic signed [63:0] h;
    h = 64'sd1 <<< (n - 1);
    return (v + (v[63] ? h - 64'sd1 : h)) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // two restoring quotient bits
  function automatic dv_t dstep(input dv_t v, input logic [17:0] d);
    logic [18:0] r;
    for (int k = 0; k < 2; k++) begin
      r     = {v.rem[17:0], v.nlo[17]};
      v.nlo = {v.nlo[16:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r   = r - {1'b0, d};
        v.q = {v.q[16:0], 1'b1};
      end else begin
        v.q = {v.q[16:0], 1'b0};
      end
      v.rem = r;
    end
    return v;
  endfunction

  function automatic bk_t f_div(input bk_t x);
    x.dv_p = dstep(x.dv_p, x.dd);
    x.dv_n = dstep(x.dv_n, x.dd);
    return x;
  endfunction

  function automatic bk_t f_s0(input tcbk_pkg::entry_t h);
    bk_t                x;
    logic [33:0]        np, nn;
    logic signed [16:0] tx, cx, bx, ntx, fcs;
    logic signed [35:0] dm36, dp36, nb36;
    x    = '0;
    np   = {1'b0, h.dfp_mag, 16'b0} + {17'b0, h.span_mag};
    nn   = {1'b0, h.dfn_mag, 16'b0} + {17'b0, h.span_mag};
    x.dd = {h.span_mag, 1'b0};
    x.dv_p.rem = {3'b0, np[33:18]};
    x.dv_p.nlo = np[17:0];
    x.dv_n.rem = {3'b0, nn[33:18]};
    x.dv_n.nlo = nn[17:0];
    x.ovf_p = ({2'b0, np[33:18]} >= x.dd);
    x.ovf_n = ({2'b0, nn[33:18]} >= x.dd);
    x.kind      = h.kind;
    x.span_zero = h.span_zero;
    x.neg_p     = h.neg_p;
    x.neg_n     = h.neg_n;
    x.dm        = h.dm;
    x.dp        = h.dp;
    tx  = $signed({h.tension[15], h.tension});
    cx  = $signed({h.continuity[15], h.continuity});
    bx  = $signed({h.bias[15], h.bias});
    ntx = $signed({h.next_tension[15], h.next_tension});
    x.tm2 = ONE17 - tx;
    x.cm  = ONE17 - cx;
    x.cp  = ONE17 + cx;
    x.bm  = ONE17 - bx;
    x.bp  = ONE17 + bx;
    x.ntm = ONE17 - ntx;
    fcs   = cx[16] ? -cx : cx;
    x.fc  = fcs;
    x.g   = 18'sd16384 - $signed({1'b0, fcs});
    dm36  = $signed({{3{h.dm[32]}}, h.dm});
    dp36  = $signed({{3{h.dp[32]}}, h.dp});
    nb36  = $signed({{4{h.nb[31]}}, h.nb});
    case (h.kind)
      tcbk_pkg::KIND_TWO_KEY:    x.e = dp36;
      tcbk_pkg::KIND_OPEN_FIRST: x.e = dp36 + (dp36 <<< 1) - nb36;
      tcbk_pkg::KIND_OPEN_LAST:  x.e = dm36 + (dm36 <<< 1) - nb36;
      default:                   x.e = '0;
    endcase
    return x;
  endfunction

  function automatic bk_t f_s1(input bk_t xi);
    bk_t x;
    x       = f_div(xi);
    x.tmcm  = 19'(rnd64(64'(x.tm2 * x.cm), 15));
    x.tmcp  = 19'(rnd64(64'(x.tm2 * x.cp), 15));
    x.eprod = x.e * x.tm2;
    x.nprod = x.dp * x.ntm;
    return x;
  endfunction

  function automatic bk_t f_s2(input bk_t xi);
    bk_t x;
    x       = f_div(xi);
    x.pb_sm = x.tmcm * x.bp;
    x.pb_sp = x.tmcp * x.bm;
    x.pb_dm = x.tmcp * x.bp;
    x.pb_dp = x.tmcm * x.bm;
    x.oval  = (x.kind == tcbk_pkg::KIND_TWO_KEY) ? sat32(rnd64(64'(x.eprod), 14))
                                                 : sat32(rnd64(64'(x.eprod), 15));
    x.nval  = sat32(rnd64(64'(x.nprod), 14));
    return x;
  endfunction

  // clamp quotient to 2.0 and apply sign
  function automatic bk_t f_s10(input bk_t xi);
    bk_t         x;
    logic [16:0] qp, qn;
    x  = xi;
    qp = (x.ovf_p || x.dv_p.q > 18'd32768) ? 17'd32768 : x.dv_p.q[16:0];
    qn = (x.ovf_n || x.dv_n.q > 18'd32768) ? 17'd32768 : x.dv_n.q[16:0];
    x.fr_p = x.neg_p ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
    x.fr_n = x.neg_n ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
    return x;
  endfunction

  function automatic bk_t f_s11(input bk_t xi);
    bk_t x;
    x      = xi;
    x.ad_p = x.fr_p * x.g + $signed({6'b0, x.fc, 14'b0});
    x.ad_n = x.fr_n * x.g + $signed({6'b0, x.fc, 14'b0});
    return x;
  endfunction

  function automatic logic signed [17:0] clampr(input logic signed [63:0] v);
    if (v > 64'sd32768) begin
      return 18'sd32768;
    end else if (v < -64'sd32768) begin
      return -18'sd32768;
    end
    return v[17:0];
  endfunction

  function automatic bk_t f_s12(input bk_t xi);
    bk_t x;
    x    = xi;
    x.fp = x.span_zero ? 18'sd16384 : clampr(rnd64(64'(x.ad_p), 14));
    x.fn = x.span_zero ? 18'sd16384 : clampr(rnd64(64'(x.ad_n), 14));
    return x;
  endfunction

  function automatic bk_t f_s13(input bk_t xi);
    bk_t x;
    x       = xi;
    x.kr_sm = x.pb_sm * x.fp;
    x.kr_sp = x.pb_sp * x.fp;
    x.kr_dm = x.pb_dm * x.fn;
    x.kr_dp = x.pb_dp * x.fn;
    return x;
  endfunction

  function automatic bk_t f_s14(input bk_t xi);
    bk_t x;
    x       = xi;
    x.ks_sm = 26'(rnd64(64'(x.kr_sm), 28));
    x.ks_sp = 26'(rnd64(64'(x.kr_sp), 28));
    x.ks_dm = 26'(rnd64(64'(x.kr_dm), 28));
    x.ks_dp = 26'(rnd64(64'(x.kr_dp), 28));
    return x;
  endfunction

  function automatic bk_t f_s15(input bk_t xi);
    bk_t x;
    x      = xi;
    x.m_sm = x.ks_sm * x.dm;
    x.m_sp = x.ks_sp * x.dp;
    x.m_dm = x.ks_dm * x.dm;
    x.m_dp = x.ks_dp * x.dp;
    return x;
  endfunction

  function automatic bk_t f_s16(input bk_t xi);
    bk_t x;
    x       = xi;
    x.sum_s = x.m_sm + x.m_sp;
    x.sum_d = x.m_dm + x.m_dp;
    return x;
  endfunction

  function automatic bk_t f_s17(input bk_t xi);
    bk_t x;
    x        = xi;
    x.in_t   = '0;
    x.out_t  = '0;
    x.next_t = '0;
    case (x.kind)
      tcbk_pkg::KIND_TCB: begin
        x.in_t  = sat32(rnd64(64'(x.sum_s), 14));
        x.out_t = sat32(rnd64(64'(x.sum_d), 14));
      end
      tcbk_pkg::KIND_OPEN_FIRST: x.out_t = x.oval;
      tcbk_pkg::KIND_OPEN_LAST:  x.in_t  = x.oval;
      tcbk_pkg::KIND_TWO_KEY: begin
        x.out_t  = x.oval;
        x.next_t = x.nval;
      end
      default: ;
    endcase
    return x;
  endfunction

  bk_t           st [NS];
  bk_t           nx [NS];
  logic [NS-1:0] vld;
  logic          en;

  assign en  = !vld[NS-1] || out_ready;
  assign pop = en && head_valid;

  assign nx[0] = f_s0(head);
  assign nx[1] = f_s1(st[0]);
  assign nx[2] = f_s2(st[1]);
  for (genvar i = 3; i <= DIV_LAST; i++) begin : g_div
    assign nx[i] = f_div(st[i-1]);
  end
  assign nx[10] = f_s10(st[9]);
  assign nx[11] = f_s11(st[10]);
  assign nx[12] = f_s12(st[11]);
  assign nx[13] = f_s13(st[12]);
  assign nx[14] = f_s14(st[13]);
  assign nx[15] = f_s15(st[14]);
  assign nx[16] = f_s16(st[15]);
  assign nx[17] = f_s17(st[16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  assign out_valid       = vld[NS-1];
  assign in_tangent      = st[NS-1].in_t;
  assign out_tangent     = st[NS-1].out_t;
  assign next_in_tangent = st[NS-1].next_t;

  assert property (@(posedge clk) disable iff (rst)
    vld[12] |-> (st[12].fp <= 18'sd32768 && st[12].fp >= -18'sd32768 &&
                 st[12].fn <= 18'sd32768 && st[12].fn >= -18'sd32768))
    else $error("frame ratio outside clamp range");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && st[NS-1].kind != tcbk_pkg::KIND_TWO_KEY) |-> next_in_tangent == 32'sd0)
    else $error("next tangent set outside two-key mode");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(vld))
    else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

[rtl/tcb_spline_key_tangents_core.sv]
// Top level: Kochanek-Bartels key tangent unit (front end, queue, arithmetic pipeline).
//
// Usage notes:
//  - Input channel in_valid/in_ready carries one key request: mode, three frame
//    numbers, three values, the key's tension/continuity/bias, the neighbor
//    tangent and the next key's tension.
//  - Output channel out_valid/out_ready returns one result per request, in order:
//    in_tangent, out_tangent and next_in_tangent, all Q16.16, saturated.
//  - loop_length is written with cfg_write/cfg_data; write it only while idle.
//  - Throughput: one request per cycle, sustained unless an output stall
//    freezes the pipeline. The pipeline is 18 stages deep; the frame ratio
//    divider takes two quotient bits per stage over nine stages.
//  - An accepted request waits in the request queue, then moves through the
//    pipeline stages in order to the output register that drives out_valid.
//  - When the receiver holds out_ready low while out_valid is high, the whole
//    pipeline freezes; the front keeps accepting into the request queue
//    (QUEUE_DEPTH entries) and drops in_ready only when the queue is full.
//  - Reset (rst, synchronous) empties the queue and pipeline and clears
//    loop_length to zero.
`default_nettype none

module tcb_spline_key_tangents_core #(
  parameter int QUEUE_DEPTH = tcbk_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         func,
  input  wire logic [15:0]        prev_frame,
  input  wire logic [15:0]        cur_frame,
  input  wire logic [15:0]        next_frame,
  input  wire logic signed [31:0] prev_value,
  input  wire logic signed [31:0] cur_value,
  input  wire logic signed [31:0] next_value,
  input  wire logic signed [15:0] tension,
  input  wire logic signed [15:0] continuity,
  input  wire logic signed [15:0] bias,
  input  wire logic signed [31:0] neighbor_tangent,
  input  wire logic signed [15:0] next_tension,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      in_tangent,
  output logic signed [31:0]      out_tangent,
  output logic signed [31:0]      next_in_tangent
);

  tcbk_pkg::entry_t entry, head;
  logic             full, not_empty, pop, push;

  // decode and differences, combinational off the input ports and the loop_length register
  tcbk_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .func             (func),
    .prev_frame       (prev_frame),
    .cur_frame        (cur_frame),
    .next_frame       (next_frame),
    .prev_value       (prev_value),
    .cur_value        (cur_value),
    .next_value       (next_value),
    .tension          (tension),
    .continuity       (continuity),
    .bias             (bias),
    .neighbor_tangent (neighbor_tangent),
    .next_tension     (next_tension),
    .entry            (entry)
  );

  // ready depends only on queue space, never on in_valid
  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  tcbk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  // stalls as a whole when out_valid is high and out_ready low; last stage is the output register
  tcbk_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (not_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .in_tangent      (in_tangent),
    .out_tangent     (out_tangent),
    .next_in_tangent (next_in_tangent)
  );

endmodule

`default_nettype wire
